// ===== design/pgr_pkg.sv =====
// shared types and constants of the polygon grid rasterizer
package pgr_pkg;

  localparam logic CMD_WRITE_VERTEX = 1'b0;
  localparam logic CMD_TEST_CELL    = 1'b1;

  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CELL_SIZE    = 2'd2;
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd3;

  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 17;
  localparam int MUL_ACC_W = 67;

  localparam logic [10:0] GRID_WIDTH_RST   = 11'd1024;
  localparam logic [10:0] GRID_HEIGHT_RST  = 11'd1024;
  localparam logic [22:0] CELL_SIZE_RST    = 23'd3277;
  localparam logic [4:0]  VERTEX_COUNT_RST = 5'd0;

  typedef struct packed {
    logic [10:0] grid_width;
    logic [10:0] grid_height;
    logic [22:0] cell_size;
    logic [4:0]  vertex_count;
  } pgr_cfg_t;

  typedef struct packed {
    logic en;
    logic accum;
  } pgr_mul_ctl_t;

endpackage

// ===== design/polygon_grid_rasterizer.sv =====
// top level: register port, vertex table, multiplier and cell test sequencer
//
// Requests arrive on the in_ channel (valid/stall). A write-vertex request
// stores one vertex in the table; it gives no result.
// A test-cell request gives one result on the out_ channel: the linear cell
// index, the inside flag and the out-of-grid flag.
// A cell test holds in_stall high until the sequencer is back in idle. The
// one 34x17 multiplier forms the cell position, the linear index and then,
// for each polygon edge that straddles the cell's row, the two 67-bit cross
// products in two passes each; out-of-grid cells and polygons under three
// vertices skip the edge tests.
// The result sits in an output register; while out_stall holds it, a new
// request is still taken, and the next result waits in the sequencer until
// the register frees. The user must write the registers through the APB
// port only while no request is in flight; the block does not enforce it.
// Reset sets grid 1024 x 1024, cell size 3277 and vertex count 0;
// the vertex table is not cleared and a slot must be written before use.
module polygon_grid_rasterizer #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_GRID_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [3:0]         in_vertex_index,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic [9:0]         in_cell_col,
  input  logic [9:0]         in_cell_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        out_cell_index,
  output logic               out_inside_res,
  output logic               out_out_of_grid
);

  localparam int AW = $clog2(MAX_VERTICES);

  pgr_pkg::pgr_cfg_t cfg_r;
  logic              cfg_wr;
  logic [1:0]        reg_sel;

  logic                          ram_wr_en;
  logic [AW-1:0]                 ram_wr_addr;
  logic [63:0]                   ram_wr_data;
  logic                          ram_rd_en;
  logic [AW-1:0]                 ram_rd_addr;
  logic [63:0]                   ram_rd_data;
  pgr_pkg::pgr_mul_ctl_t         mul_ctl;
  logic [pgr_pkg::MUL_A_W-1:0]   mul_a;
  logic [pgr_pkg::MUL_B_W-1:0]   mul_b;
  logic [pgr_pkg::MUL_ACC_W-1:0] mul_acc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width   <= pgr_pkg::GRID_WIDTH_RST;
      cfg_r.grid_height  <= pgr_pkg::GRID_HEIGHT_RST;
      cfg_r.cell_size    <= pgr_pkg::CELL_SIZE_RST;
      cfg_r.vertex_count <= pgr_pkg::VERTEX_COUNT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        pgr_pkg::REG_GRID_WIDTH:   cfg_r.grid_width   <= pwdata[10:0];
        pgr_pkg::REG_GRID_HEIGHT:  cfg_r.grid_height  <= pwdata[10:0];
        pgr_pkg::REG_CELL_SIZE:    cfg_r.cell_size    <= pwdata[22:0];
        pgr_pkg::REG_VERTEX_COUNT: cfg_r.vertex_count <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pgr_pkg::REG_GRID_WIDTH:   prdata = 32'(cfg_r.grid_width);
      pgr_pkg::REG_GRID_HEIGHT:  prdata = 32'(cfg_r.grid_height);
      pgr_pkg::REG_CELL_SIZE:    prdata = 32'(cfg_r.cell_size);
      pgr_pkg::REG_VERTEX_COUNT: prdata = 32'(cfg_r.vertex_count);
      default:                   prdata = '0;
    endcase
  end

  pgr_vtx_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pgr_mul u_mul (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (mul_a),
    .b   (mul_b),
    .acc (mul_acc)
  );

  pgr_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_GRID_DIM (MAX_GRID_DIM),
    .AW           (AW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_vertex_index (in_vertex_index),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_index  (out_cell_index),
    .out_inside_res  (out_inside_res),
    .out_out_of_grid (out_out_of_grid),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .mul_ctl         (mul_ctl),
    .mul_a           (mul_a),
    .mul_b           (mul_b),
    .mul_acc         (mul_acc)
  );

endmodule

// ===== design/pgr_vtx_ram.sv =====
// vertex table: one write port, one registered read port
module pgr_vtx_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data
);

  logic [63:0] mem_r [DEPTH];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/pgr_mul.sv =====
// shared 34x17 multiplier with shifting accumulator
module pgr_mul (
  input  logic                           clk,
  input  pgr_pkg::pgr_mul_ctl_t          ctl,
  input  logic [pgr_pkg::MUL_A_W-1:0]    a,
  input  logic [pgr_pkg::MUL_B_W-1:0]    b,
  output logic [pgr_pkg::MUL_ACC_W-1:0]  acc
);

  logic [pgr_pkg::MUL_A_W+pgr_pkg::MUL_B_W-1:0] pp;
  logic [pgr_pkg::MUL_ACC_W-1:0]                acc_r;
  logic [pgr_pkg::MUL_ACC_W-1:0]                acc_nxt;

  assign pp = a * b;

  always_comb begin
    if (ctl.accum) begin
      acc_nxt = acc_r + (pgr_pkg::MUL_ACC_W'(pp) << pgr_pkg::MUL_B_W);
    end else begin
      acc_nxt = pgr_pkg::MUL_ACC_W'(pp);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== design/pgr_seq.sv =====
// cell test sequencer, edge datapath and result register
module pgr_seq #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_GRID_DIM = 1024,
  parameter int AW           = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pgr_pkg::pgr_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [3:0]                    in_vertex_index,
  input  logic signed [31:0]            in_vertex_x,
  input  logic signed [31:0]            in_vertex_y,
  input  logic [9:0]                    in_cell_col,
  input  logic [9:0]                    in_cell_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [19:0]                   out_cell_index,
  output logic                          out_inside_res,
  output logic                          out_out_of_grid,
  output logic                          ram_wr_en,
  output logic [AW-1:0]                 ram_wr_addr,
  output logic [63:0]                   ram_wr_data,
  output logic                          ram_rd_en,
  output logic [AW-1:0]                 ram_rd_addr,
  input  logic [63:0]                   ram_rd_data,
  output pgr_pkg::pgr_mul_ctl_t         mul_ctl,
  output logic [pgr_pkg::MUL_A_W-1:0]   mul_a,
  output logic [pgr_pkg::MUL_B_W-1:0]   mul_b,
  input  logic [pgr_pkg::MUL_ACC_W-1:0] mul_acc
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PX   = 4'd1;
  localparam logic [3:0] S_PY   = 4'd2;
  localparam logic [3:0] S_IDX  = 4'd3;
  localparam logic [3:0] S_LDJ  = 4'd4;
  localparam logic [3:0] S_EDGE = 4'd5;
  localparam logic [3:0] S_M0   = 4'd6;
  localparam logic [3:0] S_M1   = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_M3   = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [10:0] GRID_CAP =
    (MAX_GRID_DIM > 2047) ? 11'd2047 : 11'(MAX_GRID_DIM);
  localparam logic [4:0] VTX_CAP =
    (MAX_VERTICES > 31) ? 5'd31 : 5'(MAX_VERTICES);

  localparam int PW = pgr_pkg::MUL_ACC_W;

  logic [3:0]   state_r, state_nxt;
  logic [9:0]   col_r, col_nxt;
  logic [9:0]   row_r, row_nxt;
  logic         oog_r, oog_nxt;
  logic [4:0]   n_r, n_nxt;
  logic [32:0]  px_r, px_nxt;
  logic [32:0]  py_r, py_nxt;
  logic [19:0]  idx_r, idx_nxt;
  logic signed [31:0] xj_r, xj_nxt;
  logic signed [31:0] yj_r, yj_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic         last_r, last_nxt;
  logic [33:0]  a1_r, a1_nxt;
  logic [32:0]  b1_r, b1_nxt;
  logic [33:0]  a2_r, a2_nxt;
  logic [32:0]  b2_r, b2_nxt;
  logic         s1_r, s1_nxt;
  logic         s2_r, s2_nxt;
  logic [PW-1:0] p1_r, p1_nxt;
  logic         par_r, par_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [19:0]  out_idx_r, out_idx_nxt;
  logic         out_in_r, out_in_nxt;
  logic         out_oog_r, out_oog_nxt;

  logic [10:0]  w_cl;
  logic [10:0]  h_cl;
  logic [4:0]   n_cl;

  // edge datapath
  logic signed [31:0] xi;
  logic signed [31:0] yi;
  logic signed [34:0] px35;
  logic signed [34:0] py35;
  logic signed [34:0] xi35;
  logic signed [34:0] yi35;
  logic signed [34:0] yj35;
  logic               gt_i;
  logic               gt_j;
  logic               straddle;
  logic signed [32:0] dy;
  logic               dy_neg;
  logic [32:0]        dy_mag;
  logic signed [34:0] e_raw;
  logic signed [34:0] e_val;
  logic               e_neg;
  logic [34:0]        e_mag;
  logic signed [34:0] dxp;
  logic [34:0]        dxp_mag;
  logic signed [32:0] dxj;
  logic [32:0]        dxj_mag;
  logic               is_last;
  logic               less;

  assign w_cl = (cfg.grid_width > GRID_CAP) ? GRID_CAP : cfg.grid_width;
  assign h_cl = (cfg.grid_height > GRID_CAP) ? GRID_CAP : cfg.grid_height;
  assign n_cl = (cfg.vertex_count > VTX_CAP) ? VTX_CAP : cfg.vertex_count;

  assign xi       = signed'(ram_rd_data[31:0]);
  assign yi       = signed'(ram_rd_data[63:32]);
  assign px35     = signed'({2'b00, px_r});
  assign py35     = signed'({2'b00, py_r});
  assign xi35     = 35'(xi);
  assign yi35     = 35'(yi);
  assign yj35     = 35'(yj_r);
  assign gt_i     = yi35 > py35;
  assign gt_j     = yj35 > py35;
  assign straddle = gt_i != gt_j;
  assign dy       = 33'(yj_r) - 33'(yi);
  assign dy_neg   = dy[32];
  assign dy_mag   = dy_neg ? 33'(-dy) : 33'(dy);
  assign e_raw    = py35 - yi35;
  assign e_val    = dy_neg ? -e_raw : e_raw;
  assign e_neg    = e_val[34];
  assign e_mag    = e_neg ? 35'(-e_val) : 35'(e_val);
  assign dxp      = px35 - xi35;
  assign dxp_mag  = dxp[34] ? 35'(-dxp) : 35'(dxp);
  assign dxj      = 33'(xj_r) - 33'(xi);
  assign dxj_mag  = dxj[32] ? 33'(-dxj) : 33'(dxj);
  assign is_last  = (32'(i_r) + 32'd1) == 32'(n_r);

  // signed compare of sign and magnitude pairs
  always_comb begin
    case ({s1_r, s2_r})
      2'b00:   less = p1_r < mul_acc;
      2'b11:   less = p1_r > mul_acc;
      2'b10:   less = (p1_r != '0) || (mul_acc != '0);
      default: less = 1'b0;
    endcase
  end

  assign in_stall    = state_r != S_IDLE;
  assign ram_wr_en   = in_valid && !in_stall && (in_command == pgr_pkg::CMD_WRITE_VERTEX) &&
                       (32'(in_vertex_index) < MAX_VERTICES);
  assign ram_wr_addr = AW'(in_vertex_index);
  assign ram_wr_data = {in_vertex_y, in_vertex_x};

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    oog_nxt       = oog_r;
    n_nxt         = n_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    idx_nxt       = idx_r;
    xj_nxt        = xj_r;
    yj_nxt        = yj_r;
    i_nxt         = i_r;
    last_nxt      = last_r;
    a1_nxt        = a1_r;
    b1_nxt        = b1_r;
    a2_nxt        = a2_r;
    b2_nxt        = b2_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    p1_nxt        = p1_r;
    par_nxt       = par_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_in_nxt    = out_in_r;
    out_oog_nxt   = out_oog_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    mul_ctl       = '0;
    mul_a         = '0;
    mul_b         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_command == pgr_pkg::CMD_TEST_CELL) begin
          col_nxt   = in_cell_col;
          row_nxt   = in_cell_row;
          oog_nxt   = (11'(in_cell_col) >= w_cl) || (11'(in_cell_row) >= h_cl);
          n_nxt     = n_cl;
          state_nxt = S_PX;
        end
      end
      S_PX: begin
        mul_ctl.en = 1'b1;
        mul_a      = pgr_pkg::MUL_A_W'(cfg.cell_size);
        mul_b      = pgr_pkg::MUL_B_W'(col_r);
        state_nxt  = S_PY;
      end
      S_PY: begin
        px_nxt     = mul_acc[32:0];
        mul_ctl.en = 1'b1;
        mul_a      = pgr_pkg::MUL_A_W'(cfg.cell_size);
        mul_b      = pgr_pkg::MUL_B_W'(row_r);
        state_nxt  = S_IDX;
      end
      S_IDX: begin
        py_nxt      = mul_acc[32:0];
        mul_ctl.en  = 1'b1;
        mul_a       = pgr_pkg::MUL_A_W'(w_cl);
        mul_b       = pgr_pkg::MUL_B_W'(row_r);
        ram_rd_en   = 1'b1;
        ram_rd_addr = AW'(n_r - 5'd1);
        state_nxt   = S_LDJ;
      end
      S_LDJ: begin
        idx_nxt     = mul_acc[19:0] + 20'(col_r);
        xj_nxt      = xi;
        yj_nxt      = yi;
        ram_rd_en   = 1'b1;
        ram_rd_addr = '0;
        i_nxt       = '0;
        par_nxt     = 1'b0;
        if (oog_r || n_r < 5'd3) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        xj_nxt      = xi;
        yj_nxt      = yi;
        ram_rd_en   = 1'b1;
        ram_rd_addr = i_r + AW'(1);
        i_nxt       = i_r + AW'(1);
        last_nxt    = is_last;
        a1_nxt      = dxp_mag[33:0];
        b1_nxt      = dy_mag;
        s1_nxt      = dxp[34];
        a2_nxt      = e_mag[33:0];
        b2_nxt      = dxj_mag;
        s2_nxt      = dxj[32] ^ e_neg;
        if (straddle) begin
          state_nxt = S_M0;
        end else if (is_last) begin
          state_nxt = S_OUT;
        end
      end
      S_M0: begin
        mul_ctl.en = 1'b1;
        mul_a      = a1_r;
        mul_b      = b1_r[16:0];
        state_nxt  = S_M1;
      end
      S_M1: begin
        mul_ctl.en    = 1'b1;
        mul_ctl.accum = 1'b1;
        mul_a         = a1_r;
        mul_b         = pgr_pkg::MUL_B_W'(b1_r[32:17]);
        state_nxt     = S_M2;
      end
      S_M2: begin
        p1_nxt     = mul_acc;
        mul_ctl.en = 1'b1;
        mul_a      = a2_r;
        mul_b      = b2_r[16:0];
        state_nxt  = S_M3;
      end
      S_M3: begin
        mul_ctl.en    = 1'b1;
        mul_ctl.accum = 1'b1;
        mul_a         = a2_r;
        mul_b         = pgr_pkg::MUL_B_W'(b2_r[32:17]);
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        par_nxt = par_r ^ less;
        if (last_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = oog_r ? '0 : idx_r;
          out_in_nxt    = !oog_r && (n_r >= 5'd3) && par_r;
          out_oog_nxt   = oog_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    oog_r     <= oog_nxt;
    n_r       <= n_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    idx_r     <= idx_nxt;
    xj_r      <= xj_nxt;
    yj_r      <= yj_nxt;
    i_r       <= i_nxt;
    last_r    <= last_nxt;
    a1_r      <= a1_nxt;
    b1_r      <= b1_nxt;
    a2_r      <= a2_nxt;
    b2_r      <= b2_nxt;
    s1_r      <= s1_nxt;
    s2_r      <= s2_nxt;
    p1_r      <= p1_nxt;
    par_r     <= par_nxt;
    out_idx_r <= out_idx_nxt;
    out_in_r  <= out_in_nxt;
    out_oog_r <= out_oog_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cell_index  = out_idx_r;
  assign out_inside_res  = out_in_r;
  assign out_out_of_grid = out_oog_r;

endmodule

// ===== tb/sv/polygon_grid_rasterizer_test.sv =====
// testbench for the polygon grid rasterizer: vertex writes, cell tests and register phases
module polygon_grid_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = 16;
  localparam int GRID_LIMIT     = 1024;
  localparam int SETTLE_CYCLES  = 24;
  localparam int TAIL_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 112;
  localparam int FIXED_PHASES   = 9;
  localparam int RANDOM_PHASES  = 5;

  typedef struct {
    logic        cmd;
    logic [3:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [9:0]  col;
    logic [9:0]  row;
  } raster_req_t;

  typedef struct {
    logic [19:0] index;
    logic        covered;
    logic        off_grid;
  } cell_result_t;

  class cell_scoreboard;
    longint       vx[TABLE_DEPTH];
    longint       vy[TABLE_DEPTH];
    logic [10:0]  grid_w;
    logic [10:0]  grid_h;
    logic [22:0]  cell_sz;
    logic [4:0]   n_vert;
    cell_result_t expected_cells[$];
    int           errors;

    function new();
      grid_w  = pgr_pkg::GRID_WIDTH_RST;
      grid_h  = pgr_pkg::GRID_HEIGHT_RST;
      cell_sz = pgr_pkg::CELL_SIZE_RST;
      n_vert  = pgr_pkg::VERTEX_COUNT_RST;
      errors  = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        pgr_pkg::REG_GRID_WIDTH:   grid_w  = value[10:0];
        pgr_pkg::REG_GRID_HEIGHT:  grid_h  = value[10:0];
        pgr_pkg::REG_CELL_SIZE:    cell_sz = value[22:0];
        pgr_pkg::REG_VERTEX_COUNT: n_vert  = value[4:0];
        default: ;
      endcase
    endfunction

    // even-odd crossing count, edge test done by cross-multiplication
    function bit cell_is_inside(longint px, longint py, int n);
      int                  j;
      int                  hits;
      longint              rise;
      longint              reach;
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] c;
      logic signed [127:0] d;
      hits = 0;
      j = n - 1;
      for (int i = 0; i < n; i++) begin
        if ((vy[i] > py) != (vy[j] > py)) begin
          rise  = vy[j] - vy[i];
          reach = py - vy[i];
          if (rise < 0) begin
            rise  = -rise;
            reach = -reach;
          end
          a = px - vx[i];
          b = rise;
          c = vx[j] - vx[i];
          d = reach;
          if (a * b < c * d) hits++;
        end
        j = i;
      end
      return hits[0];
    endfunction

    function void note_request(raster_req_t r);
      cell_result_t res;
      longint       w_eff;
      longint       h_eff;
      int           n_eff;
      longint       px;
      longint       py;
      if (r.cmd == pgr_pkg::CMD_WRITE_VERTEX) begin
        vx[r.slot] = longint'(signed'(r.x));
        vy[r.slot] = longint'(signed'(r.y));
        return;
      end
      w_eff = grid_w > GRID_LIMIT ? GRID_LIMIT : grid_w;
      h_eff = grid_h > GRID_LIMIT ? GRID_LIMIT : grid_h;
      n_eff = n_vert > TABLE_DEPTH ? TABLE_DEPTH : n_vert;
      if (r.col >= w_eff || r.row >= h_eff) begin
        res = '{20'd0, 1'b0, 1'b1};
      end else begin
        px = longint'(r.col) * longint'(cell_sz);
        py = longint'(r.row) * longint'(cell_sz);
        res.index    = 20'(longint'(r.row) * w_eff + longint'(r.col));
        res.covered  = n_eff >= 3 ? cell_is_inside(px, py, n_eff) : 1'b0;
        res.off_grid = 1'b0;
      end
      expected_cells = {expected_cells, res};
    endfunction

    function void check_result(logic [19:0] index, logic covered, logic off_grid);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        $display("%0t unexpected result: expected none, actual index %0d inside %b off grid %b",
                 $time, index, covered, off_grid);
        errors++;
        return;
      end
      want = expected_cells.pop_front();
      if (index !== want.index) begin
        $display("%0t cell_index mismatch: expected %0d, actual %0d", $time, want.index, index);
        errors++;
      end
      if (covered !== want.covered) begin
        $display("%0t inside_res mismatch: expected %b, actual %b", $time, want.covered, covered);
        errors++;
      end
      if (off_grid !== want.off_grid) begin
        $display("%0t out_of_grid mismatch: expected %b, actual %b", $time, want.off_grid,
                 off_grid);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = pgr_pkg::CMD_WRITE_VERTEX;
  logic [3:0]  in_vertex_index = '0;
  logic [31:0] in_vertex_x = '0;
  logic [31:0] in_vertex_y = '0;
  logic [9:0]  in_cell_col = '0;
  logic [9:0]  in_cell_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [19:0] out_cell_index;
  logic        out_inside_res;
  logic        out_out_of_grid;

  cell_scoreboard sb = new();
  int             burst_left = 0;
  int             rx_left = 0;
  int             idle_cycles = 0;

  polygon_grid_rasterizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_vertex_index (in_vertex_index),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_index  (out_cell_index),
    .out_inside_res  (out_inside_res),
    .out_out_of_grid (out_out_of_grid)
  );

  always #10 clk = ~clk;

  // receiver: stall bursts, free runs and long stretches with no stalling
  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      rx_left <= $urandom_range(0, 40);
    end else if ($urandom_range(0, 4) != 0) begin
      out_stall <= 1'b1;
      rx_left <= $urandom_range(0, 15);
    end else begin
      rx_left <= $urandom_range(50, 300);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_cell_index, out_inside_res, out_out_of_grid);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic send_request(raster_req_t r);
    in_valid        <= 1'b1;
    in_command      <= r.cmd;
    in_vertex_index <= r.slot;
    in_vertex_x     <= r.x;
    in_vertex_y     <= r.y;
    in_cell_col     <= r.col;
    in_cell_row     <= r.row;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic send_vertex(logic [3:0] slot, logic [31:0] x, logic [31:0] y);
    send_request('{pgr_pkg::CMD_WRITE_VERTEX, slot, x, y, 10'($urandom), 10'($urandom)});
  endtask

  task automatic send_cell(logic [9:0] col, logic [9:0] row);
    send_request('{pgr_pkg::CMD_TEST_CELL, 4'($urandom), $urandom, $urandom, col, row});
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_cells.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic longint rand_span(longint lo, longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  // vertex spread around the grid area, often snapped onto a cell corner
  function automatic logic [31:0] pick_coord(longint extent, int cs);
    longint v;
    v = rand_span(-(extent / 8) - 4, extent + extent / 8 + 4);
    if (cs > 0 && $urandom_range(0, 2) == 0) v = (v / cs) * cs;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  function automatic logic [9:0] pick_cell(longint dim);
    if (dim == 0 || $urandom_range(0, 6) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, int'(dim) - 1));
  endfunction

  task automatic run_phase(int w, int h, int cs, int n, int items);
    int     sent;
    int     n_eff;
    int     poly_n;
    int     tests;
    longint w_eff;
    longint h_eff;
    longint span_x;
    longint span_y;
    drain();
    write_register(pgr_pkg::REG_GRID_WIDTH, 32'(w));
    write_register(pgr_pkg::REG_GRID_HEIGHT, 32'(h));
    write_register(pgr_pkg::REG_CELL_SIZE, 32'(cs));
    write_register(pgr_pkg::REG_VERTEX_COUNT, 32'(n));
    w_eff  = w > GRID_LIMIT ? GRID_LIMIT : w;
    h_eff  = h > GRID_LIMIT ? GRID_LIMIT : h;
    n_eff  = n > TABLE_DEPTH ? TABLE_DEPTH : n;
    span_x = w_eff * longint'(cs);
    span_y = h_eff * longint'(cs);
    sent   = 0;
    while (sent < items) begin
      poly_n = n_eff >= 3 ? n_eff : $urandom_range(1, 4);
      for (int k = 0; k < poly_n; k++) begin
        pace_sender();
        if ($urandom_range(0, 9) == 0)
          send_vertex(4'($urandom_range(0, 15)), $urandom, $urandom);
        else
          send_vertex(4'(k), pick_coord(span_x, cs), pick_coord(span_y, cs));
        sent++;
      end
      tests = $urandom_range(4, 20);
      for (int k = 0; k < tests; k++) begin
        pace_sender();
        send_cell(pick_cell(w_eff), pick_cell(h_eff));
        sent++;
      end
      if ($urandom_range(0, 15) == 0) wait_for_results();
    end
  endtask

  initial begin
    int fixed_w[FIXED_PHASES]  = '{1024, 2047, 1, 0, 37, 1024, 600, 64, 200};
    int fixed_h[FIXED_PHASES]  = '{1024, 2047, 1, 5, 19, 1024, 300, 64, 150};
    int fixed_cs[FIXED_PHASES] = '{3277, 65536, 1, 100, 0, 8388607, 4194304, 65536, 20000};
    int fixed_n[FIXED_PHASES]  = '{16, 31, 3, 5, 8, 6, 12, 2, 4};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table: a 1 m to 10 m square, then extreme coordinates
    send_vertex(4'd0, 32'h0001_0000, 32'h0001_0000);
    send_vertex(4'd1, 32'h000A_0000, 32'h0001_0000);
    send_vertex(4'd2, 32'h000A_0000, 32'h000A_0000);
    send_vertex(4'd3, 32'h0001_0000, 32'h000A_0000);
    for (int s = 4; s < TABLE_DEPTH - 1; s++)
      send_vertex(4'(s), s[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                  s[1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    send_vertex(4'd15, 32'h0, 32'hFFFF_FFFF);

    // no polygon at reset
    send_cell(10'd0, 10'd0);
    send_cell(10'd1023, 10'd1023);
    send_cell(10'd512, 10'd3);

    drain();
    write_register(pgr_pkg::REG_GRID_WIDTH, 32'd16);
    write_register(pgr_pkg::REG_GRID_HEIGHT, 32'd16);
    write_register(pgr_pkg::REG_CELL_SIZE, 32'd65536);
    write_register(pgr_pkg::REG_VERTEX_COUNT, 32'd4);
    send_cell(10'd5, 10'd5);
    send_cell(10'd0, 10'd0);
    send_cell(10'd16, 10'd3);
    send_cell(10'd3, 10'd1023);
    send_cell(10'd1, 10'd1);
    send_cell(10'd10, 10'd5);
    send_cell(10'd5, 10'd10);

    for (int p = 0; p < FIXED_PHASES; p++)
      run_phase(fixed_w[p], fixed_h[p], fixed_cs[p], fixed_n[p], PHASE_ITEMS);
    for (int p = 0; p < RANDOM_PHASES; p++)
      run_phase($urandom_range(1, 1024), $urandom_range(1, 1024),
                ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4194304)
                                            : $urandom_range(1, 70000),
                $urandom_range(0, 16), PHASE_ITEMS);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_cells.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
